// ===== hdl/jsu_pkg.sv =====
// Shared types and constants of the JSON string unescape block.
package jsu_pkg;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] ERR_UNEXPECTED   = 3'd0;
	localparam logic [2:0] ERR_UNTERM_STR   = 3'd1;
	localparam logic [2:0] ERR_UNTERM_ESC   = 3'd2;
	localparam logic [2:0] ERR_UNKNOWN_ESC  = 3'd3;
	localparam logic [2:0] ERR_TRUNC_ESC    = 3'd4;
	localparam logic [2:0] ERR_BAD_HEX      = 3'd5;

	localparam int QUEUE_DEPTH = 2;

	// One transfer from the front to the back: an optional code point that
	// the back writes out as UTF-8, followed by an optional single result.
	typedef struct packed {
		logic        has_code;
		logic [31:0] code;
		logic        has_tail;
		logic [1:0]  kind;
		logic [7:0]  tail_byte;
		logic [2:0]  err;
	} cmd_t;

endpackage

// ===== hdl/jsu_front.sv =====
// Front end: parse state machine that turns each text byte into at most one command.
module jsu_front import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] data_byte,
	input  logic       text_ended,
	output logic       push,
	output cmd_t       cmd
);

	typedef enum logic [2:0] {
		MODE_IDLE     = 3'd0,
		MODE_STR      = 3'd1,
		MODE_ESC      = 3'd2,
		MODE_HEX1     = 3'd3,
		MODE_HIGH     = 3'd4,
		MODE_HIGH_ESC = 3'd5,
		MODE_HEX2     = 3'd6
	} mode_t;

	mode_t       mode_q, mode_n;
	logic [1:0]  cnt_q, cnt_n;
	logic [15:0] acc_q, acc_n;
	logic [15:0] held_q, held_n;
	logic        bad_q, bad_n;

	logic [4:0]  hex_d;
	logic [15:0] acc_shift;
	logic        bad_shift;
	logic        esc_ok;
	logic [7:0]  esc_val;
	logic [31:0] pair_code;

	// Value of a hex digit, or 16 when the byte is not one.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd16;
		if (c inside {[8'h30:8'h39]}) t = c - 8'h30;
		else if (c inside {[8'h61:8'h66]}) t = c - 8'h57;
		else if (c inside {[8'h41:8'h46]}) t = c - 8'h37;
		return t[4:0];
	endfunction

	always_comb begin
		esc_ok = 1'b1;
		case (data_byte)
			8'h22:   esc_val = 8'h22;
			8'h5C:   esc_val = 8'h5C;
			8'h2F:   esc_val = 8'h2F;
			8'h62:   esc_val = 8'h08;
			8'h66:   esc_val = 8'h0C;
			8'h6E:   esc_val = 8'h0A;
			8'h72:   esc_val = 8'h0D;
			8'h74:   esc_val = 8'h09;
			default: begin
				esc_val = 8'h00;
				esc_ok  = 1'b0;
			end
		endcase
	end

	assign hex_d     = hex_value(data_byte);
	assign acc_shift = {acc_q[11:0], hex_d[3:0]};
	assign bad_shift = bad_q | hex_d[4];
	assign pair_code = 32'h0001_0000 + ((32'(held_q) - 32'h0000_D800) << 10)
		+ (32'(acc_shift) - 32'h0000_DC00);

	always_comb begin
		mode_n = mode_q;
		cnt_n  = cnt_q;
		acc_n  = acc_q;
		held_n = held_q;
		bad_n  = bad_q;
		cmd    = '0;
		case (mode_q)
			MODE_IDLE: begin
				if (text_ended || data_byte != 8'h22) begin
					cmd.has_tail = 1'b1;
					cmd.kind     = KIND_ERROR;
					cmd.err      = ERR_UNEXPECTED;
				end else begin
					mode_n = MODE_STR;
				end
			end
			MODE_STR, MODE_HIGH: begin
				if (mode_q == MODE_HIGH) begin
					cmd.has_code = 1'b1;
					cmd.code     = 32'(held_q);
					held_n       = '0;
				end
				if (text_ended) begin
					cmd.has_tail = 1'b1;
					cmd.kind     = KIND_ERROR;
					cmd.err      = ERR_UNTERM_STR;
				end else if (data_byte == 8'h22) begin
					cmd.has_tail = 1'b1;
					cmd.kind     = KIND_DONE;
					mode_n       = MODE_IDLE;
					held_n       = '0;
				end else if (data_byte == 8'h5C) begin
					mode_n = (mode_q == MODE_HIGH) ? MODE_HIGH_ESC : MODE_ESC;
				end else begin
					cmd.has_tail  = 1'b1;
					cmd.kind      = KIND_BYTE;
					cmd.tail_byte = data_byte;
					mode_n        = MODE_STR;
				end
			end
			MODE_ESC, MODE_HIGH_ESC: begin
				if (!text_ended && data_byte == 8'h75) begin
					mode_n = (mode_q == MODE_HIGH_ESC) ? MODE_HEX2 : MODE_HEX1;
					cnt_n  = '0;
					acc_n  = '0;
					bad_n  = 1'b0;
				end else begin
					if (mode_q == MODE_HIGH_ESC) begin
						cmd.has_code = 1'b1;
						cmd.code     = 32'(held_q);
						held_n       = '0;
					end
					cmd.has_tail = 1'b1;
					if (text_ended) begin
						cmd.kind = KIND_ERROR;
						cmd.err  = ERR_UNTERM_ESC;
					end else if (esc_ok) begin
						cmd.kind      = KIND_BYTE;
						cmd.tail_byte = esc_val;
						mode_n        = MODE_STR;
					end else begin
						cmd.kind = KIND_ERROR;
						cmd.err  = ERR_UNKNOWN_ESC;
					end
				end
			end
			MODE_HEX1, MODE_HEX2: begin
				if (text_ended) begin
					cmd.has_tail = 1'b1;
					cmd.kind     = KIND_ERROR;
					cmd.err      = ERR_TRUNC_ESC;
				end else begin
					acc_n = acc_shift;
					bad_n = bad_shift;
					if (cnt_q != 2'd3) begin
						cnt_n = cnt_q + 2'd1;
					end else begin
						cnt_n = '0;
						if (bad_shift) begin
							cmd.has_tail = 1'b1;
							cmd.kind     = KIND_ERROR;
							cmd.err      = ERR_BAD_HEX;
						end else if (mode_q == MODE_HEX1) begin
							if (acc_shift >= 16'hD800 && acc_shift < 16'hDC00) begin
								held_n = acc_shift;
								mode_n = MODE_HIGH;
							end else begin
								cmd.has_code = 1'b1;
								cmd.code     = 32'(acc_shift);
								mode_n       = MODE_STR;
							end
						end else begin
							cmd.has_code = 1'b1;
							cmd.code     = pair_code;
							held_n       = '0;
							mode_n       = MODE_STR;
						end
					end
				end
			end
			default: begin
				mode_n = MODE_IDLE;
				cnt_n  = '0;
				acc_n  = '0;
				held_n = '0;
				bad_n  = 1'b0;
			end
		endcase
		// Every failure drops the whole parse state.
		if (cmd.has_tail && cmd.kind == KIND_ERROR) begin
			mode_n = MODE_IDLE;
			cnt_n  = '0;
			acc_n  = '0;
			held_n = '0;
			bad_n  = 1'b0;
		end
	end

	assign push = fire && (cmd.has_code || cmd.has_tail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cnt_q  <= '0;
			acc_q  <= '0;
			held_q <= '0;
			bad_q  <= 1'b0;
		end else if (fire) begin
			mode_q <= mode_n;
			cnt_q  <= cnt_n;
			acc_q  <= acc_n;
			held_q <= held_n;
			bad_q  <= bad_n;
		end
	end

endmodule

// ===== hdl/jsu_queue.sv =====
// Two-entry command queue between the front and the back.
module jsu_queue import jsu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic not_empty,
	output logic not_full,
	output cmd_t head
);

	cmd_t       mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign not_empty = (count_q != 2'd0);
	assign not_full  = (count_q != 2'(QUEUE_DEPTH));
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule

// ===== hdl/jsu_back.sv =====
// Back end: expands each command into UTF-8 bytes and results, one per cycle while the output is not stalled.
module jsu_back import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] result_kind,
	output logic [2:0] error_code,
	output logic       last_of_run
);

	logic [7:0] enc_bytes [4];
	logic [2:0] enc_n;

	logic       cur_valid_q;
	logic [7:0] cur_bytes_q [4];
	logic [2:0] cur_ncode_q;
	logic       cur_has_tail_q;
	logic [1:0] cur_kind_q;
	logic [7:0] cur_tail_byte_q;
	logic [2:0] cur_err_q;
	logic [2:0] cur_idx_q;

	logic [2:0] total;
	logic       emit;
	logic       is_last;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] out_kind_q;
	logic [2:0] out_err_q;
	logic       out_last_q;

	// UTF-8 encoding of the head command's code point.
	always_comb begin
		logic [31:0] c;
		c = q_head.code;
		enc_bytes[0] = '0;
		enc_bytes[1] = '0;
		enc_bytes[2] = '0;
		enc_bytes[3] = '0;
		if (c < 32'h80) begin
			enc_n        = 3'd1;
			enc_bytes[0] = c[7:0];
		end else if (c < 32'h800) begin
			enc_n        = 3'd2;
			enc_bytes[0] = 8'hC0 | {3'b000, c[10:6]};
			enc_bytes[1] = 8'h80 | {2'b00, c[5:0]};
		end else if (c < 32'h1_0000) begin
			enc_n        = 3'd3;
			enc_bytes[0] = 8'hE0 | {4'h0, c[15:12]};
			enc_bytes[1] = 8'h80 | {2'b00, c[11:6]};
			enc_bytes[2] = 8'h80 | {2'b00, c[5:0]};
		end else begin
			enc_n        = 3'd4;
			enc_bytes[0] = 8'hF0 | c[25:18];
			enc_bytes[1] = 8'h80 | {2'b00, c[17:12]};
			enc_bytes[2] = 8'h80 | {2'b00, c[11:6]};
			enc_bytes[3] = 8'h80 | {2'b00, c[5:0]};
		end
		if (!q_head.has_code) enc_n = 3'd0;
	end

	assign total   = cur_ncode_q + {2'b00, cur_has_tail_q};
	assign emit    = cur_valid_q && (!out_valid_q || out_ready);
	assign is_last = (cur_idx_q == total - 3'd1);
	assign q_pop   = q_valid && (!cur_valid_q || (emit && is_last));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_bytes_q     <= enc_bytes;
			cur_ncode_q     <= enc_n;
			cur_has_tail_q  <= q_head.has_tail;
			cur_kind_q      <= q_head.kind;
			cur_tail_byte_q <= q_head.tail_byte;
			cur_err_q       <= q_head.err;
		end
		if (emit) begin
			out_last_q <= is_last;
			if (cur_idx_q < cur_ncode_q) begin
				out_byte_q <= cur_bytes_q[cur_idx_q[1:0]];
				out_kind_q <= KIND_BYTE;
				out_err_q  <= '0;
			end else begin
				out_byte_q <= cur_tail_byte_q;
				out_kind_q <= cur_kind_q;
				out_err_q  <= cur_err_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				cur_idx_q   <= '0;
			end else if (emit) begin
				cur_idx_q <= cur_idx_q + 3'd1;
				if (is_last) cur_valid_q <= 1'b0;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign result_kind = out_kind_q;
	assign error_code  = out_err_q;
	assign last_of_run = out_last_q;

endmodule

// ===== hdl/json_string_unescape_utf8_top.sv =====
// Top level of the JSON string unescape block with UTF-8 output.
//
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid / in_ready  data_byte, text_ended
//  out      output     out_valid/out_ready  out_byte, result_kind, error_code, last_of_run
//
// The block accepts one text byte per cycle as long as each byte yields at most one
// result and the output is not stalled; a byte that yields several results holds the output port until all have gone.
// The output register, fed by one expansion stage, limits the rate: it moves one
// result per cycle while out_ready allows, and a two-entry command queue lets the parser keep going meanwhile.
// A result passes through the command queue and the expansion stage on its way to the output register.
// Reset is asynchronous and returns the parser to idle, awaiting an opening quote.
// A stall on the output fills the queue, after which in_ready drops until a slot frees.
module json_string_unescape_utf8_top import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       text_ended,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] result_kind,
	output logic [2:0] error_code,
	output logic       last_of_run
);

	logic fire;
	logic push;
	cmd_t cmd;
	logic q_not_empty;
	logic q_not_full;
	cmd_t q_head;
	logic q_pop;

	// The parser state moves on every input transfer; the queue must have room for
	// whatever command that byte produces, so readiness depends on queue space only.
	assign in_ready = q_not_full;
	assign fire     = in_valid && in_ready;

	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.data_byte  (data_byte),
		.text_ended (text_ended),
		.push       (push),
		.cmd        (cmd)
	);

	jsu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (cmd),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.not_full  (q_not_full),
		.head      (q_head)
	);

	// The back end writes code points out as UTF-8 and then the closing result.
	jsu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.result_kind (result_kind),
		.error_code  (error_code),
		.last_of_run (last_of_run)
	);

`ifndef SYNTHESIS
	// Completion and error results carry no byte.
	a_no_byte_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_BYTE |-> out_byte == 8'h00)
		else $error("status result carries a nonzero byte");

	// Only error results carry an error code.
	a_code_only_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_ERROR |-> error_code == ERR_UNEXPECTED)
		else $error("non-error result carries an error code");

	// Completion and errors always close the run of one input byte.
	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != KIND_BYTE |-> last_of_run)
		else $error("status result is not the last of its run");
`endif

endmodule

// ===== verif/jsu_decode_checker.sv =====
// Checker that predicts the decoded results of the JSON string unescape block and compares them.
`timescale 1ns / 100ps

module jsu_decode_checker import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       text_ended,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic [1:0] result_kind,
	input  logic [2:0] error_code,
	input  logic       last_of_run,
	output int         fail_count,
	output int         results_due
);

	localparam logic [2:0] NO_ERROR = 3'd0;

	typedef enum logic [2:0] {
		PARSE_IDLE,
		PARSE_STRING,
		PARSE_ESCAPE,
		PARSE_HEX_FIRST,
		PARSE_HIGH_HELD,
		PARSE_HIGH_ESCAPE,
		PARSE_HEX_SECOND
	} parse_mode_t;

	typedef struct packed {
		logic [7:0] value;
		logic [1:0] kind;
		logic [2:0] err;
		logic       last;
	} decoded_t;

	parse_mode_t mode;
	logic [1:0]  digits;
	logic [15:0] accum;
	logic [15:0] high_half;
	logic        bad_digit;

	decoded_t decoded_q[$];
	decoded_t want;
	int       size_before;

	function automatic void clear_state();
		mode = PARSE_IDLE;
		digits = 2'd0;
		accum = 16'h0000;
		high_half = 16'h0000;
		bad_digit = 1'b0;
	endfunction

	function automatic void push_result(logic [1:0] kind, logic [7:0] value, logic [2:0] err);
		decoded_t r;
		r.value = value;
		r.kind = kind;
		r.err = err;
		r.last = 1'b0;
		decoded_q = {decoded_q, r};
	endfunction

	// Any failure drops the whole parse back to idle.
	function automatic void raise_error(logic [2:0] err);
		clear_state();
		push_result(KIND_ERROR, 8'h00, err);
	endfunction

	function automatic void encode_utf8(logic [31:0] code);
		if (code < 32'h80) begin
			push_result(KIND_BYTE, code[7:0], NO_ERROR);
		end else if (code < 32'h800) begin
			push_result(KIND_BYTE, {3'b110, code[10:6]}, NO_ERROR);
			push_result(KIND_BYTE, {2'b10, code[5:0]}, NO_ERROR);
		end else if (code < 32'h10000) begin
			push_result(KIND_BYTE, {4'b1110, code[15:12]}, NO_ERROR);
			push_result(KIND_BYTE, {2'b10, code[11:6]}, NO_ERROR);
			push_result(KIND_BYTE, {2'b10, code[5:0]}, NO_ERROR);
		end else begin
			// Wrapped codes can exceed 21 bits; the lead byte keeps only its low eight bits.
			push_result(KIND_BYTE, 8'hF0 | code[25:18], NO_ERROR);
			push_result(KIND_BYTE, {2'b10, code[17:12]}, NO_ERROR);
			push_result(KIND_BYTE, {2'b10, code[11:6]}, NO_ERROR);
			push_result(KIND_BYTE, {2'b10, code[5:0]}, NO_ERROR);
		end
	endfunction

	// Returns 16 for a byte that is not a hex digit.
	function automatic logic [4:0] nibble_of(logic [7:0] c);
		logic [7:0] v;
		v = 8'h10;
		if (c >= "0" && c <= "9")
			v = c - "0";
		else if (c >= "a" && c <= "f")
			v = c - "a" + 8'd10;
		else if (c >= "A" && c <= "F")
			v = c - "A" + 8'd10;
		return v[4:0];
	endfunction

	function automatic void simple_escape(logic [7:0] c);
		logic [7:0] value;
		case (c)
			"\"": value = "\"";
			"\\": value = "\\";
			"/": value = "/";
			"b": value = 8'h08;
			"f": value = 8'h0C;
			"n": value = 8'h0A;
			"r": value = 8'h0D;
			"t": value = 8'h09;
			default: begin
				raise_error(ERR_UNKNOWN_ESC);
				return;
			end
		endcase
		mode = PARSE_STRING;
		push_result(KIND_BYTE, value, NO_ERROR);
	endfunction

	function automatic void start_hex(parse_mode_t next_mode);
		mode = next_mode;
		digits = 2'd0;
		accum = 16'h0000;
		bad_digit = 1'b0;
	endfunction

	function automatic void string_byte(logic [7:0] c);
		if (c == "\"") begin
			push_result(KIND_DONE, 8'h00, NO_ERROR);
			mode = PARSE_IDLE;
			high_half = 16'h0000;
		end else if (c == "\\") begin
			mode = PARSE_ESCAPE;
		end else begin
			mode = PARSE_STRING;
			push_result(KIND_BYTE, c, NO_ERROR);
		end
	endfunction

	function automatic void hex_digit(logic [7:0] c);
		logic [4:0]  d;
		logic [31:0] code;
		d = nibble_of(c);
		if (d[4])
			bad_digit = 1'b1;
		accum = {accum[11:0], d[3:0]};
		if (digits != 2'd3) begin
			digits = digits + 2'd1;
			return;
		end
		digits = 2'd0;
		if (bad_digit) begin
			raise_error(ERR_BAD_HEX);
			return;
		end
		if (mode == PARSE_HEX_FIRST) begin
			if (accum >= 16'hD800 && accum < 16'hDC00) begin
				high_half = accum;
				mode = PARSE_HIGH_HELD;
				return;
			end
			mode = PARSE_STRING;
			encode_utf8({16'h0000, accum});
			return;
		end
		// Second half of a pair: combined with 32-bit wrap and not validated.
		code = 32'h10000 + (({16'h0000, high_half} - 32'hD800) << 10)
			+ ({16'h0000, accum} - 32'hDC00);
		high_half = 16'h0000;
		mode = PARSE_STRING;
		encode_utf8(code);
	endfunction

	function automatic void decode_item(logic [7:0] c, logic ended);
		case (mode)
			PARSE_IDLE: begin
				if (ended || c != "\"")
					raise_error(ERR_UNEXPECTED);
				else
					mode = PARSE_STRING;
			end
			PARSE_STRING: begin
				if (ended)
					raise_error(ERR_UNTERM_STR);
				else
					string_byte(c);
			end
			PARSE_ESCAPE: begin
				if (ended)
					raise_error(ERR_UNTERM_ESC);
				else if (c == "u")
					start_hex(PARSE_HEX_FIRST);
				else
					simple_escape(c);
			end
			PARSE_HEX_FIRST, PARSE_HEX_SECOND: begin
				if (ended)
					raise_error(ERR_TRUNC_ESC);
				else
					hex_digit(c);
			end
			PARSE_HIGH_HELD: begin
				encode_utf8({16'h0000, high_half});
				high_half = 16'h0000;
				if (ended)
					raise_error(ERR_UNTERM_STR);
				else if (c == "\\")
					mode = PARSE_HIGH_ESCAPE;
				else
					string_byte(c);
			end
			PARSE_HIGH_ESCAPE: begin
				if (!ended && c == "u") begin
					start_hex(PARSE_HEX_SECOND);
				end else begin
					encode_utf8({16'h0000, high_half});
					high_half = 16'h0000;
					if (ended)
						raise_error(ERR_UNTERM_ESC);
					else
						simple_escape(c);
				end
			end
			default: clear_state();
		endcase
	endfunction

	function automatic void check_field(string name, logic [7:0] expected, logic [7:0] actual);
		if (expected !== actual) begin
			$error("%s: expected %0h, actual %0h", name, expected, actual);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			decoded_q.delete();
			fail_count = 0;
			results_due <= 0;
		end else begin
			if (in_valid && in_ready) begin
				size_before = decoded_q.size();
				decode_item(data_byte, text_ended);
				if (decoded_q.size() > size_before)
					decoded_q[decoded_q.size() - 1].last = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					$error("result with nothing expected: kind %0d, byte %0h",
						result_kind, out_byte);
					fail_count++;
				end else begin
					want = decoded_q.pop_front();
					check_field("out_byte", want.value, out_byte);
					check_field("result_kind", {6'd0, want.kind}, {6'd0, result_kind});
					check_field("error_code", {5'd0, want.err}, {5'd0, error_code});
					check_field("last_of_run", {7'd0, want.last}, {7'd0, last_of_run});
				end
			end
			results_due <= decoded_q.size();
		end
	end

endmodule

// ===== verif/tb_json_string_unescape_utf8_top.sv =====
// Testbench top: feeds JSON string literals into the unescape block and gives the verdict.
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8_top;

	// No new literal starts once this many bytes have been sent.
	localparam int ITEM_TARGET   = 270;
	// From here on neither side idles, so the tail of the run goes at full rate.
	localparam int CALM_FROM     = 230;
	// Once this many bytes are in, the receiver holds off long enough for the
	// command queue to fill and the input to back up.
	localparam int HOLD_AT       = 120;
	localparam int HOLD_CYCLES   = 80;
	// Cycles without any transfer on either channel before the run is declared hung.
	localparam int STALL_LIMIT   = 2000;
	// Margin after the last result has come back, before the verdict is given.
	localparam int SETTLE_CYCLES = 8;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       text_ended;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic [1:0] result_kind;
	logic [2:0] error_code;
	logic       last_of_run;

	int fail_count;
	int results_due;
	int sent_count   = 0;
	int stall_cycles = 0;
	bit calm         = 1'b0;
	bit holding      = 1'b0;
	bit hold_done    = 1'b0;
	// When clear, the sender offers bytes back to back for the current literal.
	bit gappy        = 1'b0;

	json_string_unescape_utf8_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.text_ended (text_ended),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.result_kind(result_kind),
		.error_code (error_code),
		.last_of_run(last_of_run)
	);

	jsu_decode_checker unescape_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.text_ended (text_ended),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.result_kind(result_kind),
		.error_code (error_code),
		.last_of_run(last_of_run),
		.fail_count (fail_count),
		.results_due(results_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a long run of cycles with no transfer on either side means the block hung.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver side. Ready comes in random stretches high and low, except for one
	// long hold-off and the calm tail of the run.
	initial begin
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!hold_done && sent_count >= HOLD_AT) begin
				hold_done = 1'b1;
				holding = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Offers one byte and returns at the edge where its transfer happens. Valid stays
	// high into the next call unless that call opens an idle gap first.
	task automatic send_item(input logic [7:0] value, input logic ended);
		if (gappy && !calm && !holding && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= value;
		text_ended <= ended;
		do @(posedge clk); while (!in_ready);
		sent_count++;
	endtask

	// The end marker carries a random byte, which the block must ignore.
	task automatic send_end();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	task automatic send_escape(input logic [7:0] letter);
		send_item("\\", 1'b0);
		send_item(letter, 1'b0);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] nib);
		logic [7:0] base;
		if (nib < 4'd10)
			base = "0";
		else if ($urandom_range(0, 1) != 0)
			base = "a" - 8'd10;
		else
			base = "A" - 8'd10;
		return base + {4'h0, nib};
	endfunction

	function automatic bit is_hex(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	// Any byte that neither closes the string nor starts an escape.
	function automatic logic [7:0] plain_byte();
		logic [7:0] v;
		do v = 8'($urandom_range(0, 255)); while (v == "\"" || v == "\\");
		return v;
	endfunction

	function automatic logic [7:0] escape_letter();
		case ($urandom_range(0, 7))
			0: return "\"";
			1: return "\\";
			2: return "/";
			3: return "b";
			4: return "f";
			5: return "n";
			6: return "r";
			default: return "t";
		endcase
	endfunction

	function automatic logic [7:0] unknown_letter();
		logic [7:0] v;
		bit known;
		do begin
			v = 8'($urandom_range(0, 255));
			case (v)
				"\"", "\\", "/", "b", "f", "n", "r", "t", "u": known = 1'b1;
				default: known = 1'b0;
			endcase
		end while (known);
		return v;
	endfunction

	function automatic logic [15:0] high_surrogate();
		return 16'hD800 + 16'($urandom_range(0, 1023));
	endfunction

	// A \uXXXX escape; with spoil set, one of the four digits is replaced by a non-hex byte.
	task automatic send_unicode(input logic [15:0] code, input bit spoil);
		int bad_pos;
		logic [7:0] junk;
		bad_pos = spoil ? int'($urandom_range(0, 3)) : -1;
		send_escape("u");
		for (int i = 3; i >= 0; i--) begin
			if (i == bad_pos) begin
				do junk = 8'($urandom_range(0, 255)); while (is_hex(junk));
				send_item(junk, 1'b0);
			end else begin
				send_item(hex_char(code[i*4 +: 4]), 1'b0);
			end
		end
	endtask

	// One random literal with random content: more often broken at the end than closed
	// properly, and now and then plain noise while the parser is idle.
	task automatic send_literal();
		gappy = $urandom_range(0, 2) != 0;
		if ($urandom_range(0, 9) == 0) begin
			if ($urandom_range(0, 1) != 0)
				send_end();
			else
				send_item(plain_byte(), 1'b0);
			return;
		end
		send_text("\"");
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 9))
				0, 1, 2: send_item(plain_byte(), 1'b0);
				3: send_escape(escape_letter());
				4: send_unicode(16'($urandom_range(0, 16'h7F)), 1'b0);
				5: send_unicode(16'($urandom_range(16'h80, 16'h7FF)), 1'b0);
				6: send_unicode(16'($urandom_range(16'h800, 16'hFFFF)), 1'b0);
				7: begin
					// Surrogate pair; the low half is occasionally out of range.
					send_unicode(high_surrogate(), 1'b0);
					if ($urandom_range(0, 4) != 0)
						send_unicode(16'hDC00 + 16'($urandom_range(0, 1023)), 1'b0);
					else
						send_unicode(16'($urandom_range(0, 16'hFFFF)), 1'b0);
				end
				8: begin
					// High half followed by something other than a second \u.
					send_unicode(high_surrogate(), 1'b0);
					if ($urandom_range(0, 1) != 0)
						send_item(plain_byte(), 1'b0);
					else
						send_escape(escape_letter());
				end
				default: send_unicode(16'($urandom_range(0, 16'hFFFF)), 1'b0);
			endcase
		end
		case ($urandom_range(0, 13))
			0: send_end();
			1: begin
				send_item("\\", 1'b0);
				send_end();
			end
			2: send_escape(unknown_letter());
			3: send_unicode(16'($urandom_range(0, 16'hFFFF)), 1'b1);
			4: begin
				// Text runs out inside the hex group, possibly after a bad digit.
				send_escape("u");
				repeat ($urandom_range(0, 3))
					send_item(($urandom_range(0, 1) != 0) ?
						hex_char(4'($urandom_range(0, 15))) : plain_byte(), 1'b0);
				send_end();
			end
			5: begin
				send_unicode(high_surrogate(), 1'b0);
				send_end();
			end
			6: begin
				send_unicode(high_surrogate(), 1'b0);
				send_item("\\", 1'b0);
				send_end();
			end
			7: begin
				send_unicode(high_surrogate(), 1'b0);
				send_escape(unknown_letter());
			end
			default: send_text("\"");
		endcase
	endtask

	// Stops offering and waits until the checker holds no outstanding result.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		text_ended <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. End marker and a stray byte while idle, both extremes of the
		// byte inside a string, a simple escape, a surrogate pair written as four UTF-8
		// bytes, and an unknown escape letter.
		gappy = 1'b1;
		send_item(8'hFF, 1'b1);
		send_text("A");
		send_text("\"");
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_text("\\t\"");
		send_text("\"\\uD83D\\ude00\"");
		send_text("\"\\q");

		// The sender pauses here until every result of the directed part has come back.
		wait_for_results();

		while (sent_count < ITEM_TARGET) begin
			if (sent_count >= CALM_FROM)
				calm = 1'b1;
			send_literal();
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && results_due == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== json_string_unescape_utf8_top.f =====
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8_top.sv
verif/jsu_decode_checker.sv
verif/tb_json_string_unescape_utf8_top.sv
